### rtl/ens_pkg.sv
// shared constants, types and register codes for the edge non-maximum suppression block
package ens_pkg;

   // frame geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);

   // field widths
   localparam int MAG_W    = 16;
   localparam int DIR_W    = 15;
   localparam int WIDTH_W  = 11;
   localparam int HEIGHT_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register codes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   // register reset values
   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

   // axis boundaries in Q2.13 radians: pi/8 and 3pi/8
   localparam logic signed [DIR_W-1:0] AXIS_LOW  = 15'sd3217;
   localparam logic signed [DIR_W-1:0] AXIS_HIGH = 15'sd9651;

   typedef struct packed {
      logic [MAG_W-1:0]    threshold;
      logic [WIDTH_W-1:0]  frame_width;
      logic [HEIGHT_W-1:0] frame_height;
   } cfg_type;

   // where the current input sits and what its result refers to
   typedef struct packed {
      logic             pad;
      logic [COL_W-1:0] col;
      logic             out_valid;
      logic             frame_last;
      logic             interior;
   } pos_type;

   // line buffer read data for one column
   typedef struct packed {
      logic [MAG_W-1:0] up2_mag;
      logic [MAG_W-1:0] up1_mag;
      logic [DIR_W-1:0] up1_dir;
   } line_rd_type;

endpackage

### rtl/ens_req_if.sv
// pixel input channel
interface ens_req_if;
   import ens_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [MAG_W-1:0]        magnitude;
   logic signed [DIR_W-1:0] direction;

   modport source(output valid, output magnitude, output direction, input ready);
   modport sink(input valid, input magnitude, input direction, output ready);
endinterface

### rtl/ens_rsp_if.sv
// suppressed pixel result channel
interface ens_rsp_if;
   import ens_pkg::*;

   logic             valid;
   logic             ready;
   logic             out_valid;
   logic [MAG_W-1:0] suppressed_value;
   logic             frame_last;

   modport source(output valid, output out_valid, output suppressed_value, output frame_last,
                  input ready);
   modport sink(input valid, input out_valid, input suppressed_value, input frame_last,
                output ready);
endinterface

### rtl/ens_pos_ctrl.sv
// raster position counters and decode of the window center position
module ens_pos_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  ens_pkg::cfg_type cfg,
   input  logic             accept,
   output ens_pkg::pos_type pos
);
   import ens_pkg::*;

   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic signed [HEIGHT_W+1:0] ro;
   logic signed [HEIGHT_W+1:0] h_s;
   logic [WIDTH_W:0]    co;
   logic [WIDTH_W:0]    w_x;
   logic [WIDTH_W:0]    col_next;

   // clamp register values to the supported range
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_eff = WIDTH_W'(1);
      end else if (cfg.frame_width > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         w_eff = cfg.frame_width;
      end
      if (cfg.frame_height == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if ({1'b0, cfg.frame_height} > (HEIGHT_W+1)'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = cfg.frame_height;
      end
   end

   // window center trails the input by one row and one pixel
   always_comb begin
      h_s = signed'({2'b00, h_eff});
      w_x = {1'b0, w_eff};
      if (col_ff != '0) begin
         ro = signed'({2'b00, row_ff}) - (HEIGHT_W+2)'(1);
         co = {{(WIDTH_W+1-COL_W){1'b0}}, col_ff} - (WIDTH_W+1)'(1);
      end else begin
         ro = signed'({2'b00, row_ff}) - (HEIGHT_W+2)'(2);
         co = w_x - (WIDTH_W+1)'(1);
      end
      pos.pad        = row_ff >= h_eff;
      pos.col        = col_ff;
      pos.out_valid  = !ro[HEIGHT_W+1] && (ro < h_s) && (co < w_x);
      pos.frame_last = pos.out_valid && (ro == h_s - (HEIGHT_W+2)'(1))
                       && (co == w_x - (WIDTH_W+1)'(1));
      pos.interior   = pos.out_valid && (ro >= (HEIGHT_W+2)'(1))
                       && (ro + (HEIGHT_W+2)'(2) <= h_s)
                       && (co >= (WIDTH_W+1)'(1)) && (co + (WIDTH_W+1)'(2) <= w_x);
   end

   // advance through the frame plus its flush padding
   always_comb begin
      col_next = {{(WIDTH_W+1-COL_W){1'b0}}, col_ff} + (WIDTH_W+1)'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if ({1'b0, row_ff} >= {1'b0, h_eff} + (HEIGHT_W+1)'(1)) begin
            col_in = '0;
            row_in = '0;
         end else if (col_next >= w_x) begin
            col_in = '0;
            row_in = row_ff + HEIGHT_W'(1);
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

### rtl/ens_line_buf.sv
// line buffers for the two rows above and the direction row, with write forwarding
module ens_line_buf (
   input  logic                       clock,
   input  logic                       accept,
   input  logic                       step,
   input  logic [ens_pkg::COL_W-1:0]  addr,
   input  logic [ens_pkg::MAG_W-1:0]  wr_mag,
   input  logic [ens_pkg::DIR_W-1:0]  wr_dir,
   output ens_pkg::line_rd_type       rd
);
   import ens_pkg::*;

   logic [MAG_W-1:0] row1_mem [MAX_WIDTH];
   logic [MAG_W-1:0] row2_mem [MAX_WIDTH];
   logic [DIR_W-1:0] dir_mem  [MAX_WIDTH];

   logic [MAG_W-1:0] up1_ff;
   logic [MAG_W-1:0] up2_ff;
   logic [DIR_W-1:0] dir_ff;
   logic [COL_W-1:0] addr_ff;
   logic             fwd;

   // the older row is written only on step, so bypass it to a reader of the same column
   assign fwd = step && (addr_ff == addr);

   // row above: read old value, write the new pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         up1_ff         <= row1_mem[addr];
         row1_mem[addr] <= wr_mag;
         addr_ff        <= addr;
      end
   end

   // two rows above: filled from the row above once that value is read out
   always_ff @(posedge clock) begin
      if (step) begin
         row2_mem[addr_ff] <= up1_ff;
      end
      if (accept) begin
         up2_ff <= fwd ? up1_ff : row2_mem[addr];
      end
   end

   // direction of the row above
   always_ff @(posedge clock) begin
      if (accept) begin
         dir_ff        <= dir_mem[addr];
         dir_mem[addr] <= wr_dir;
      end
   end

   assign rd.up2_mag = up2_ff;
   assign rd.up1_mag = up1_ff;
   assign rd.up1_dir = dir_ff;

endmodule

### rtl/ens_nms_core.sv
// 3x3 window, axis choice, suppression compare and result register with handshake
module ens_nms_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   ens_rsp_if.source                 rsp_chan,
   input  ens_pkg::pos_type          pos,
   input  logic [ens_pkg::MAG_W-1:0] in_mag,
   input  ens_pkg::line_rd_type      lb,
   input  logic [ens_pkg::MAG_W-1:0] threshold,
   output logic                      accept,
   output logic                      step
);
   import ens_pkg::*;

   logic                    s1_valid_ff, s1_valid_in;
   logic [MAG_W-1:0]        s1_mag_ff;
   pos_type                 s1_pos_ff;
   logic [MAG_W-1:0]        win_ff [6];
   logic [MAG_W-1:0]        win_in [6];
   logic signed [DIR_W-1:0] cdir_ff, cdir_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    out_valid_ff;
   logic [MAG_W-1:0]        value_ff, value_in;
   logic                    last_ff;
   logic                    out_en;
   logic [MAG_W-1:0]        m, nb_a, nb_b;
   logic signed [DIR_W-1:0] t;

   // handshake: the result register frees the window stage, which frees the input
   assign out_en    = !rsp_valid_ff || rsp_chan.ready;
   assign step      = s1_valid_ff && out_en;
   assign req_ready = !s1_valid_ff || out_en;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // pick the neighbor pair along the quantized gradient axis
   always_comb begin
      t = cdir_ff;
      m = win_ff[4];
      if (t <= AXIS_LOW && t >= -AXIS_LOW) begin
         nb_a = lb.up1_mag;
         nb_b = win_ff[1];
      end else if (t > AXIS_LOW && t < AXIS_HIGH) begin
         nb_a = lb.up2_mag;
         nb_b = win_ff[2];
      end else if (t < -AXIS_LOW && t > -AXIS_HIGH) begin
         nb_a = s1_mag_ff;
         nb_b = win_ff[0];
      end else begin
         nb_a = win_ff[3];
         nb_b = win_ff[5];
      end
      value_in = '0;
      if (s1_pos_ff.interior && m >= threshold && m > nb_a && m > nb_b) begin
         value_in = m;
      end
   end

   // shift the window by one column
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i];
      end
      cdir_in = cdir_ff;
      if (step) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i] = win_ff[3+i];
         end
         win_in[3] = lb.up2_mag;
         win_in[4] = lb.up1_mag;
         win_in[5] = s1_mag_ff;
         cdir_in   = signed'(lb.up1_dir);
      end
   end

   // control and window state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cdir_ff      <= '0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cdir_ff      <= cdir_in;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mag_ff <= in_mag;
         s1_pos_ff <= pos;
      end
      if (step) begin
         out_valid_ff <= s1_pos_ff.out_valid;
         value_ff     <= value_in;
         last_ff      <= s1_pos_ff.frame_last;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.out_valid        = out_valid_ff;
   assign rsp_chan.suppressed_value = value_ff;
   assign rsp_chan.frame_last       = last_ff;

endmodule

### rtl/edge_nonmax_suppression.sv
// top level of the edge non-maximum suppression block
//
// Takes a raster stream of gradient pixels (magnitude Q12.4, direction Q2.13
// radians) on req_chan, one pixel per transaction, and gives one result per
// transaction on rsp_chan. Each result refers to the pixel one row plus one
// pixel earlier, so after each frame the source sends frame_width+1 padding
// transactions to flush the rest; out_valid marks results that carry a frame
// pixel and frame_last marks the frame's final pixel.
// Each transaction is registered into the window stage and then into the
// result register, which holds it while rsp_chan stalls. Throughput: one
// transaction per cycle unless rsp_chan stalls; each line buffer is read and
// written once per pixel and the window logic fits between two registers.
// csr_we writes threshold, frame_width and frame_height by index; write them
// only while no transaction is in flight.
// Reset clears the position counters, the window and the handshake state and
// loads the register defaults (threshold 0, 640 x 480); the line buffers need
// no clearing. When rsp_chan stalls, one more transaction is taken into the
// window stage and then req_chan.ready drops until the result is taken.
module edge_nonmax_suppression (
   input  logic                           clock,
   input  logic                           reset,
   ens_req_if.sink                        req_chan,
   ens_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [ens_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ens_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ens_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   pos_type          pos;
   line_rd_type      lb_rd;
   logic             accept;
   logic             step;
   logic             req_ready;
   logic [MAG_W-1:0] in_mag;
   logic [DIR_W-1:0] in_dir;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_THRESHOLD:    cfg_in.threshold    = csr_wdata;
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_wdata[WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_wdata[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold    <= '0;
         cfg_ff.frame_width  <= RESET_WIDTH;
         cfg_ff.frame_height <= RESET_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // padding transactions enter as zero
   assign in_mag = pos.pad ? '0 : req_chan.magnitude;
   assign in_dir = pos.pad ? '0 : req_chan.direction;
   assign req_chan.ready = req_ready;

   ens_pos_ctrl u_pos_ctrl (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .pos    (pos)
   );

   ens_line_buf u_line_buf (
      .clock  (clock),
      .accept (accept),
      .step   (step),
      .addr   (pos.col),
      .wr_mag (in_mag),
      .wr_dir (in_dir),
      .rd     (lb_rd)
   );

   ens_nms_core u_nms_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_chan  (rsp_chan),
      .pos       (pos),
      .in_mag    (in_mag),
      .lb        (lb_rd),
      .threshold (cfg_ff.threshold),
      .accept    (accept),
      .step      (step)
   );

endmodule

### bench/edge_nonmax_suppression_test.sv
// self-checking testbench for the edge non-maximum suppression block
module edge_nonmax_suppression_test;
   import ens_pkg::*;

   // one result as it leaves the block
   typedef struct packed {
      logic             out_valid;
      logic [MAG_W-1:0] suppressed_value;
      logic             frame_last;
   } nms_result_type;

   typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_type;

   // one row of the directed table: a pixel, or a register write between transactions
   typedef struct packed {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [MAG_W-1:0]     word;
      logic [DIR_W-1:0]     angle;
      logic                 known;
      nms_result_type       want;
   } bench_step_type;

   localparam nms_result_type NO_PIXEL   = '{1'b0, 16'd0, 1'b0};
   localparam nms_result_type LAST_EMPTY = '{1'b1, 16'd0, 1'b1};

   localparam int DIRECTED_LEN     = 29;
   localparam int LONG_HOLD_AT     = 60;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int RUN_LIMIT_CYCLES = 500000;

   localparam bench_step_type DIRECTED [DIRECTED_LEN] = '{
      // warm-up right after reset, still at the 640 x 480 default
      '{STEP_PIXEL, '0, 16'hFFFF, -15'sd16384, 1'b1, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'h0000, 15'sd16383, 1'b1, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'h8000, 15'sd3217, 1'b1, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'h0001, -15'sd3217, 1'b1, NO_PIXEL},
      // narrow to 5 x 3 in the middle of row 0
      '{STEP_WRITE, CSR_THRESHOLD, 16'd256, '0, 1'b0, NO_PIXEL},
      '{STEP_WRITE, CSR_FRAME_WIDTH, 16'd5, '0, 1'b0, NO_PIXEL},
      '{STEP_WRITE, CSR_FRAME_HEIGHT, 16'd3, '0, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'd200, 15'sd0, 1'b0, NO_PIXEL},
      // row 1: horizontal at threshold, vertical, down-right and up-right diagonals at the limits
      '{STEP_PIXEL, '0, 16'd100, 15'sd0, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'd256, 15'sd3217, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'd200, 15'sd9651, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'hFFFF, -15'sd9650, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'd50, 15'sd9650, 1'b0, NO_PIXEL},
      // row 2
      '{STEP_PIXEL, '0, 16'd10, 15'sd0, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'd20, -15'sd16384, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'd30, 15'sd16383, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'd40, -15'sd3218, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'd255, 15'sd3218, 1'b0, NO_PIXEL},
      // flush, padding magnitudes must not leak into the window
      '{STEP_PIXEL, '0, 16'hFFFF, 15'sd16383, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'hFFFF, 15'sd16383, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'hFFFF, 15'sd16383, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'hFFFF, 15'sd16383, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'hFFFF, 15'sd16383, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'hFFFF, 15'sd16383, 1'b0, NO_PIXEL},
      // zero width and height act as a one-pixel frame
      '{STEP_WRITE, CSR_FRAME_WIDTH, 16'd0, '0, 1'b0, NO_PIXEL},
      '{STEP_WRITE, CSR_FRAME_HEIGHT, 16'd0, '0, 1'b0, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'hFFFF, 15'sd0, 1'b1, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'hFFFF, 15'sd0, 1'b1, NO_PIXEL},
      '{STEP_PIXEL, '0, 16'hFFFF, 15'sd0, 1'b1, LAST_EMPTY}
   };

   logic clock;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ens_req_if pixel_chan ();
   ens_rsp_if result_chan ();

   edge_nonmax_suppression u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (pixel_chan),
      .rsp_chan  (result_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies as the block should hold them
   logic [MAG_W-1:0]    cfg_threshold;
   logic [WIDTH_W-1:0]  cfg_width;
   logic [HEIGHT_W-1:0] cfg_height;

   // line buffers, 3x3 window and raster position of the suppression predictor
   logic [MAG_W-1:0] line_mag [0:2*MAX_WIDTH-1];
   logic [DIR_W-1:0] line_dir [0:MAX_WIDTH-1];
   logic [MAG_W-1:0] win_mag [0:5];
   logic [DIR_W-1:0] win_dir;
   int               cur_col;
   int               cur_row;

   nms_result_type suppressed_due [$];
   int             fail_count = 0;
   int             taken_count = 0;
   int             send_idle_pct;
   int             take_idle_pct;
   int             hold_left;
   bit             hold_done;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int frame_cols();
      int w;
      w = cfg_width;
      if (w < 1) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int frame_rows();
      int h;
      h = cfg_height;
      if (h < 1) h = 1;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      return h;
   endfunction

   // advance the predictor by one pixel and give the result it causes
   task automatic suppress_pixel(input logic [MAG_W-1:0] mag, input logic [DIR_W-1:0] dir,
                                 output nms_result_type res);
      int w, h, r, c, ci, ro, co, t, dx, dy, i, lo, hi;
      logic [MAG_W-1:0] g [0:2][0:2];
      logic [MAG_W-1:0] m;
      logic signed [DIR_W-1:0] cdir;
      bit pad;
      w = frame_cols();
      h = frame_rows();
      r = cur_row;
      c = cur_col;
      ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
      pad = (r >= h);
      lo = AXIS_LOW;
      hi = AXIS_HIGH;

      // newest column: two rows above from the line buffers, this row from the input
      g[0][2] = line_mag[MAX_WIDTH + ci];
      g[1][2] = line_mag[ci];
      g[2][2] = pad ? '0 : mag;
      line_mag[MAX_WIDTH + ci] = g[1][2];
      line_mag[ci] = g[2][2];
      for (i = 0; i < 3; i++) begin
         g[i][0] = win_mag[i];
         g[i][1] = win_mag[3 + i];
      end
      cdir = win_dir;
      win_dir = line_dir[ci];
      line_dir[ci] = pad ? '0 : dir;

      // the window center sits one row and one pixel back
      if (c >= 1) begin
         ro = r - 1;
         co = c - 1;
      end else begin
         ro = r - 2;
         co = w - 1;
      end

      res = NO_PIXEL;
      if (ro >= 0 && ro < h && co < w) begin
         res.out_valid = 1'b1;
         res.frame_last = (ro == h - 1 && co == w - 1);
         if (ro >= 1 && ro <= h - 2 && co >= 1 && co <= w - 2) begin
            m = g[1][1];
            t = cdir;
            // quantize the direction to one of four axes
            if (t <= lo && t >= -lo) begin
               dx = 1;
               dy = 0;
            end else if (t > lo && t < hi) begin
               dx = 1;
               dy = -1;
            end else if (t < -lo && t > -hi) begin
               dx = 1;
               dy = 1;
            end else begin
               dx = 0;
               dy = -1;
            end
            if (m >= cfg_threshold && m > g[1 + dy][1 + dx] && m > g[1 - dy][1 - dx])
               res.suppressed_value = m;
         end
      end

      for (i = 0; i < 3; i++) begin
         win_mag[i] = g[i][1];
         win_mag[3 + i] = g[i][2];
      end

      // raster position, including the padding rows
      if (r >= h + 1) begin
         cur_row = 0;
         cur_col = 0;
      end else if (c + 1 >= w) begin
         cur_col = 0;
         cur_row = r + 1;
      end else begin
         cur_col = c + 1;
      end
   endtask

   // offer one pixel, with random idle cycles ahead of it, until it is taken
   task automatic offer_pixel(input logic [MAG_W-1:0] mag, input logic [DIR_W-1:0] dir,
                              output nms_result_type pred);
      while ($urandom_range(99) < send_idle_pct) begin
         pixel_chan.valid <= 1'b0;
         @(posedge clock);
      end
      pixel_chan.valid     <= 1'b1;
      pixel_chan.magnitude <= mag;
      pixel_chan.direction <= dir;
      @(posedge clock);
      while (!pixel_chan.ready) @(posedge clock);
      suppress_pixel(mag, dir, pred);
   endtask

   task automatic send_random_pixel();
      logic [MAG_W-1:0] mag;
      logic [DIR_W-1:0] dir;
      nms_result_type pred;
      // ties and extremes are common so that strict comparison matters
      case ($urandom_range(7))
         0: mag = '1;
         1: mag = '0;
         2: mag = MAG_W'($urandom_range(3));
         default: mag = MAG_W'($urandom_range(16'hFFFF));
      endcase
      // lean on the axis boundaries
      case ($urandom_range(15))
         0: dir = AXIS_LOW;
         1: dir = -AXIS_LOW;
         2: dir = AXIS_LOW + 15'sd1;
         3: dir = -(AXIS_LOW + 15'sd1);
         4: dir = AXIS_HIGH;
         5: dir = -AXIS_HIGH;
         6: dir = AXIS_HIGH - 15'sd1;
         7: dir = -(AXIS_HIGH - 15'sd1);
         8: dir = 15'h4000;
         9: dir = 15'h3FFF;
         default: dir = DIR_W'($urandom_range(15'h7FFF));
      endcase
      offer_pixel(mag, dir, pred);
      suppressed_due.push_back(pred);
   endtask

   // stop offering and let every outstanding result come back
   task automatic settle_results();
      pixel_chan.valid <= 1'b0;
      while (suppressed_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_THRESHOLD:    cfg_threshold = data;
         CSR_FRAME_WIDTH:  cfg_width = data[WIDTH_W-1:0];
         CSR_FRAME_HEIGHT: cfg_height = data[HEIGHT_W-1:0];
         default: ;
      endcase
   endtask

   // new settings, close any frame left open, then whole frames plus a partial tail
   task automatic run_frames(input logic [CSR_DATA_W-1:0] thr, input logic [CSR_DATA_W-1:0] width,
                             input logic [CSR_DATA_W-1:0] height, input int frames,
                             input int extra);
      int cycle_len;
      settle_results();
      write_register(CSR_THRESHOLD, thr);
      write_register(CSR_FRAME_WIDTH, width);
      write_register(CSR_FRAME_HEIGHT, height);
      while (cur_col != 0 || cur_row != 0) send_random_pixel();
      cycle_len = frame_cols() * frame_rows() + frame_cols() + 1;
      repeat (frames * cycle_len + extra) send_random_pixel();
   endtask

   // result side: random back-pressure plus one long hold-off once the stream is going
   always @(posedge clock) begin
      if (reset) begin
         result_chan.ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         result_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && taken_count >= LONG_HOLD_AT) begin
         result_chan.ready <= 1'b0;
         hold_left <= LONG_HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         result_chan.ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // compare each taken result with the oldest one due
   always @(posedge clock) begin
      nms_result_type want;
      if (!reset && result_chan.valid && result_chan.ready) begin
         taken_count <= taken_count + 1;
         if (suppressed_due.size() == 0) begin
            $error("result transaction with nothing due");
            fail_count++;
         end else begin
            want = suppressed_due.pop_front();
            if (result_chan.out_valid !== want.out_valid) begin
               $error("out_valid: expected %0d, got %0d", want.out_valid,
                      result_chan.out_valid);
               fail_count++;
            end
            if (result_chan.suppressed_value !== want.suppressed_value) begin
               $error("suppressed_value: expected %0d, got %0d", want.suppressed_value,
                      result_chan.suppressed_value);
               fail_count++;
            end
            if (result_chan.frame_last !== want.frame_last) begin
               $error("frame_last: expected %0d, got %0d", want.frame_last,
                      result_chan.frame_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #(RUN_LIMIT_CYCLES * 4);
      $display("edge_nonmax_suppression test failed");
      $finish;
   end

   initial begin
      nms_result_type pred;
      int i;
      pixel_chan.valid     = 1'b0;
      pixel_chan.magnitude = '0;
      pixel_chan.direction = '0;
      result_chan.ready    = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      cfg_threshold = '0;
      cfg_width     = RESET_WIDTH;
      cfg_height    = RESET_HEIGHT;
      for (i = 0; i < 2 * MAX_WIDTH; i++) line_mag[i] = '0;
      for (i = 0; i < MAX_WIDTH; i++) line_dir[i] = '0;
      for (i = 0; i < 6; i++) win_mag[i] = '0;
      win_dir = '0;
      cur_col = 0;
      cur_row = 0;
      send_idle_pct = 35;
      take_idle_pct = 78;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < DIRECTED_LEN; i++) begin
         if (DIRECTED[i].kind == STEP_WRITE) begin
            settle_results();
            write_register(DIRECTED[i].reg_index, DIRECTED[i].word);
         end else begin
            offer_pixel(DIRECTED[i].word, DIRECTED[i].angle, pred);
            suppressed_due.push_back(DIRECTED[i].known ? DIRECTED[i].want : pred);
         end
      end

      // sender mostly busy, receiver mostly stalled
      run_frames(16'd0, 16'd4, 16'd4, 2, 0);
      run_frames(CSR_DATA_W'($urandom_range(16'h0FFF)), 16'd7, 16'd5, 1, 0);
      run_frames(16'hFFFF, 16'd3, 16'd3, 2, 0);

      // the other way round; a one-row frame writes the columns the widening below reads
      send_idle_pct = 78;
      take_idle_pct = 35;
      run_frames(CSR_DATA_W'($urandom_range(16'h0FFF)), 16'd12, 16'd1, 1, 0);
      run_frames(CSR_DATA_W'($urandom_range(16'h0FFF)), 16'd8, 16'd6, 1, 30);
      // widen in the middle of a frame
      run_frames(CSR_DATA_W'($urandom_range(16'h0FFF)), 16'd12, 16'd4, 1, 0);

      // no idling on either side
      send_idle_pct = 0;
      take_idle_pct = 0;
      run_frames(CSR_DATA_W'($urandom_range(16'h0FFF)), 16'd6, 16'd4, 1, 20);
      // row already past the new frame end
      run_frames(CSR_DATA_W'($urandom_range(16'h0FFF)), 16'd5, 16'd2, 1, 0);
      run_frames(CSR_DATA_W'($urandom_range(16'h0FFF)), 16'd2, 16'd3, 1, 0);
      run_frames(CSR_DATA_W'($urandom_range(16'hFFFF)), 16'd6, 16'd5, 1, 0);

      settle_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("edge_nonmax_suppression test passed");
      else
         $display("edge_nonmax_suppression test failed");
      $finish;
   end

endmodule

### sim.f
rtl/ens_pkg.sv
rtl/ens_req_if.sv
rtl/ens_rsp_if.sv
rtl/ens_pos_ctrl.sv
rtl/ens_line_buf.sv
rtl/ens_nms_core.sv
rtl/edge_nonmax_suppression.sv
bench/edge_nonmax_suppression_test.sv
